### hw/rtl/okvt_pkg.sv
// ----------------------------------------------------------------------------
// okvt_pkg
// Shared types and constants of the ordered key-value table.
// ----------------------------------------------------------------------------
package okvt_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int FIELD_W = 32;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_EXISTS   = 3'd2,
        CMD_RENAME   = 3'd3,
        CMD_READ     = 3'd4,
        CMD_WRITE    = 3'd5,
        CMD_READ_POS = 3'd6,
        CMD_CLEAR    = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_POS,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic shift_wr;
        logic capture;
        logic shift_start;
        logic pos_read;
        logic commit;
    } dp_ctrl_t;

    typedef struct packed {
        logic hit;
        logic drained;
        logic out_free;
        cmd_t req_cmd;
    } dp_stat_t;

endpackage

### hw/rtl/okvt_ctrl.sv
// ----------------------------------------------------------------------------
// okvt_ctrl
// Request sequencer: scan, shift, position read and result commit.
// ----------------------------------------------------------------------------
module okvt_ctrl
    import okvt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CMD_W-1:0] cmd,
    input  dp_stat_t         stat,
    output dp_ctrl_t         ctrl
);

    state_t state_reg;
    state_t state_next;
    cmd_t   cmd_in;

    assign cmd_in = cmd_t'(cmd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_in)
                        CMD_CLEAR:    state_next = S_FINISH;
                        CMD_READ_POS: state_next = S_POS;
                        default:      state_next = S_SCAN;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = (stat.req_cmd == CMD_DELETE) ? S_SHIFT : S_FINISH;
                end
                else if (stat.drained)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                if (stat.drained)
                begin
                    state_next = S_FINISH;
                end
            end
            S_POS:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    ctrl.capture     = 1'b1;
                    ctrl.shift_start = (stat.req_cmd == CMD_DELETE);
                end
                else if (!stat.drained)
                begin
                    ctrl.step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                ctrl.step     = 1'b1;
                ctrl.shift_wr = 1'b1;
            end
            S_POS:
            begin
                ctrl.pos_read = 1'b1;
            end
            S_FINISH:
            begin
                ctrl.commit = stat.out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

### hw/rtl/okvt_datapath.sv
// ----------------------------------------------------------------------------
// okvt_datapath
// Entry memories, scan and shift pipeline, entry count and result register.
// ----------------------------------------------------------------------------
module okvt_datapath
    import okvt_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_ctrl_t           ctrl,
    output dp_stat_t           stat,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [FIELD_W-1:0] key,
    input  logic [FIELD_W-1:0] new_key,
    input  logic [FIELD_W-1:0] value,
    input  logic [POS_W-1:0]   position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               found,
    output logic [FIELD_W-1:0] key_out,
    output logic [FIELD_W-1:0] value_out,
    output logic [COUNT_W-1:0] count
);

    localparam int IW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PCW = (CW > POS_W) ? CW : POS_W;

    logic [KEY_WIDTH-1:0]   entry_keys   [DEPTH];
    logic [VALUE_WIDTH-1:0] entry_values [DEPTH];

    cmd_t                   req_cmd_reg;
    logic [KEY_WIDTH-1:0]   req_key_reg;
    logic [KEY_WIDTH-1:0]   req_new_key_reg;
    logic [VALUE_WIDTH-1:0] req_value_reg;
    logic [POS_W-1:0]       req_pos_reg;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [CW-1:0]          scan_idx_reg;
    logic                   cmp_valid_reg;
    logic [IW-1:0]          cmp_idx_reg;

    logic                   found_reg;
    logic [IW-1:0]          hit_idx_reg;
    logic [VALUE_WIDTH-1:0] hit_value_reg;

    logic [KEY_WIDTH-1:0]   rd_key_reg;
    logic [VALUE_WIDTH-1:0] rd_value_reg;

    logic                   out_valid_reg;
    status_t                status_reg;
    logic                   found_out_reg;
    logic [KEY_WIDTH-1:0]   key_out_reg;
    logic [VALUE_WIDTH-1:0] value_out_reg;
    logic [COUNT_W-1:0]     count_out_reg;

    logic                   issue;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic                   hit;
    logic                   full;
    logic                   pos_ok;
    logic                   shift_we;

    status_t                res_status;
    logic                   res_found;
    logic [KEY_WIDTH-1:0]   res_key;
    logic [VALUE_WIDTH-1:0] res_value;
    logic                   cm_key_we;
    logic                   cm_val_we;
    logic [IW-1:0]          cm_addr;
    logic [KEY_WIDTH-1:0]   cm_key;

    logic                   key_we;
    logic                   val_we;
    logic [IW-1:0]          wr_addr;
    logic [KEY_WIDTH-1:0]   wr_key;
    logic [VALUE_WIDTH-1:0] wr_value;

    assign issue   = ctrl.step && (scan_idx_reg < count_reg);
    assign rd_en   = issue || ctrl.pos_read;
    assign rd_addr = ctrl.pos_read ? IW'(req_pos_reg) : scan_idx_reg[IW-1:0];
    assign hit     = cmp_valid_reg && (rd_key_reg == req_key_reg);
    assign full    = (count_reg >= CW'(DEPTH));
    assign pos_ok  = (PCW'(req_pos_reg) < PCW'(count_reg));

    assign stat.hit      = hit;
    assign stat.drained  = !cmp_valid_reg && (scan_idx_reg >= count_reg);
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.req_cmd  = req_cmd_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            req_cmd_reg     <= cmd_t'(cmd);
            req_key_reg     <= KEY_WIDTH'(key);
            req_new_key_reg <= KEY_WIDTH'(new_key);
            req_value_reg   <= VALUE_WIDTH'(value);
            req_pos_reg     <= position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
        end
        else if (ctrl.load)
        begin
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (ctrl.shift_start)
        begin
            scan_idx_reg  <= CW'(cmp_idx_reg) + CW'(1);
            cmp_valid_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            cmp_valid_reg <= issue;
            if (issue)
            begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
                cmp_idx_reg  <= scan_idx_reg[IW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            hit_idx_reg   <= cmp_idx_reg;
            hit_value_reg <= rd_value_reg;
        end
    end

    always_comb
    begin
        res_status = ST_OK;
        res_found  = 1'b0;
        res_key    = '0;
        res_value  = '0;
        count_next = count_reg;
        cm_key_we  = 1'b0;
        cm_val_we  = 1'b0;
        cm_addr    = hit_idx_reg;
        cm_key     = req_new_key_reg;
        case (req_cmd_reg)
            CMD_INSERT:
            begin
                if (found_reg)
                begin
                    res_status = ST_DUPLICATE;
                    res_found  = 1'b1;
                    res_value  = hit_value_reg;
                end
                else if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    cm_key_we  = 1'b1;
                    cm_val_we  = 1'b1;
                    cm_addr    = count_reg[IW-1:0];
                    cm_key     = req_key_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_DELETE:
            begin
                if (found_reg)
                begin
                    res_found  = 1'b1;
                    res_value  = hit_value_reg;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    res_status = ST_NOT_FOUND;
                end
            end
            CMD_EXISTS, CMD_READ:
            begin
                if (found_reg)
                begin
                    res_found = 1'b1;
                    res_value = hit_value_reg;
                end
                else
                begin
                    res_status = ST_NOT_FOUND;
                end
            end
            CMD_RENAME:
            begin
                if (found_reg)
                begin
                    res_found = 1'b1;
                    res_value = hit_value_reg;
                    cm_key_we = 1'b1;
                end
                else
                begin
                    res_status = ST_NOT_FOUND;
                end
            end
            CMD_WRITE:
            begin
                if (found_reg)
                begin
                    res_found = 1'b1;
                    res_value = req_value_reg;
                    cm_val_we = 1'b1;
                end
                else
                begin
                    res_status = ST_NOT_FOUND;
                end
            end
            CMD_READ_POS:
            begin
                if (pos_ok)
                begin
                    res_found = 1'b1;
                    res_key   = rd_key_reg;
                    res_value = rd_value_reg;
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    assign shift_we = ctrl.shift_wr && cmp_valid_reg;
    assign key_we   = shift_we || (ctrl.commit && cm_key_we);
    assign val_we   = shift_we || (ctrl.commit && cm_val_we);
    assign wr_addr  = shift_we ? (cmp_idx_reg - IW'(1)) : cm_addr;
    assign wr_key   = shift_we ? rd_key_reg : cm_key;
    assign wr_value = shift_we ? rd_value_reg : req_value_reg;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            entry_keys[wr_addr] <= wr_key;
        end
        if (val_we)
        begin
            entry_values[wr_addr] <= wr_value;
        end
        if (rd_en)
        begin
            rd_key_reg   <= entry_keys[rd_addr];
            rd_value_reg <= entry_values[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            status_reg    <= res_status;
            found_out_reg <= res_found;
            key_out_reg   <= res_key;
            value_out_reg <= res_value;
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_out_reg;
    assign key_out   = FIELD_W'(key_out_reg);
    assign value_out = FIELD_W'(value_out_reg);
    assign count     = count_out_reg;

endmodule

### hw/rtl/ordered_key_value_table_top.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table_top
// Key-value table kept in insertion order, searched key by key.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (cmd, key, new_key, value, position) and
// each one produces exactly one result on the out channel (status, found,
// key_out, value_out, count). Both channels use valid/ready.
// A key lookup reads one stored entry per cycle from the oldest one on and
// stops at the first hit, or once every entry is compared on a miss; an
// insert of a new key is a miss. A delete then moves every later entry down
// one place at one entry per cycle. Read position reads only the entry at
// that position, and clear goes straight to its result. The entry memory
// has a single read port. One request is in work at a time, and the next
// request is taken in the cycle after a result is issued.
// The result sits in an output register: while the receiver stalls, the next
// request is still accepted and worked on, and it waits at its final step
// until the held result is taken.
// Reset empties the table at once; stored entries are not cleared.
// ----------------------------------------------------------------------------
module ordered_key_value_table_top
    import okvt_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [FIELD_W-1:0] key,
    input  logic [FIELD_W-1:0] new_key,
    input  logic [FIELD_W-1:0] value,
    input  logic [POS_W-1:0]   position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               found,
    output logic [FIELD_W-1:0] key_out,
    output logic [FIELD_W-1:0] value_out,
    output logic [COUNT_W-1:0] count
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    okvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    okvt_datapath #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cmd       (cmd),
        .key       (key),
        .new_key   (new_key),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .found     (found),
        .key_out   (key_out),
        .value_out (value_out),
        .count     (count)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while a request is in work");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= DEPTH))
        else $error("entry count beyond table depth");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (status == ST_OK) || (status == ST_DUPLICATE))
        else $error("found set with a failing status");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_FOUND) |-> !found && (value_out == '0))
        else $error("miss carries found or a value");

endmodule

### verif/ordered_key_value_table_tb.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table testbench
// Drives key-value table requests through a valid/ready channel in several
// phases of sender idling and receiver stalling. A local copy of the table
// predicts every result at acceptance, and the monitor compares each result
// field by field with the oldest prediction. Random requests draw most keys
// from a small pool so that hits, duplicates, full tables and deletes with
// shifts happen often.
// ----------------------------------------------------------------------------
module tb;
    import okvt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH      = 16;
    localparam int KEY_POOL_N       = 24;
    localparam int RANDOM_PER_PHASE = 425;
    localparam int PHASES           = 4;
    localparam int DRAIN_CYCLES     = 64;

    typedef struct {
        cmd_t        op;
        logic [31:0] key;
        logic [31:0] new_key;
        logic [31:0] value;
        logic [3:0]  pos;
    } request_t;

    typedef struct {
        status_t     status;
        logic        found;
        logic [31:0] key_out;
        logic [31:0] value_out;
        logic [4:0]  count;
    } result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CMD_W-1:0]   cmd = '0;
    logic [FIELD_W-1:0] key = '0;
    logic [FIELD_W-1:0] new_key = '0;
    logic [FIELD_W-1:0] value = '0;
    logic [POS_W-1:0]   position = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic               found;
    logic [FIELD_W-1:0] key_out;
    logic [FIELD_W-1:0] value_out;
    logic [COUNT_W-1:0] count;

    request_t    pending_requests[$];
    result_t     expected_results[$];
    request_t    held_req;
    result_t     want;
    logic [31:0] table_keys[TABLE_DEPTH];
    logic [31:0] table_vals[TABLE_DEPTH];
    int          table_count = 0;
    logic [31:0] key_pool[KEY_POOL_N];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          error_count = 0;
    int          idle_plan[PHASES] = '{0, 80, 0, 24};
    int          stall_plan[PHASES] = '{0, 0, 80, 24};

    ordered_key_value_table_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .key       (key),
        .new_key   (new_key),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .found     (found),
        .key_out   (key_out),
        .value_out (value_out),
        .count     (count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic request_t make_request(cmd_t op, logic [31:0] k, logic [31:0] nk,
                                              logic [31:0] v, logic [3:0] p);
        request_t r;
        r.op      = op;
        r.key     = k;
        r.new_key = nk;
        r.value   = v;
        r.pos     = p;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 30)
            r.op = CMD_INSERT;
        else if (pick < 45)
            r.op = CMD_DELETE;
        else if (pick < 55)
            r.op = CMD_EXISTS;
        else if (pick < 63)
            r.op = CMD_RENAME;
        else if (pick < 75)
            r.op = CMD_READ;
        else if (pick < 87)
            r.op = CMD_WRITE;
        else if (pick < 97)
            r.op = CMD_READ_POS;
        else
            r.op = CMD_CLEAR;
        r.key     = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL_N-1)]
                                               : $urandom();
        r.new_key = ($urandom_range(99) < 70) ? key_pool[$urandom_range(KEY_POOL_N-1)]
                                               : $urandom();
        r.value   = $urandom();
        r.pos     = 4'($urandom_range(15));
        return r;
    endfunction

    // Update the local table and return the result the request must produce.
    function automatic result_t apply_request(request_t r);
        result_t res;
        int      hit;
        res.status    = ST_OK;
        res.found     = 1'b0;
        res.key_out   = '0;
        res.value_out = '0;
        hit = -1;
        for (int i = table_count - 1; i >= 0; i--)
            if (table_keys[i] == r.key)
                hit = i;
        case (r.op)
            CMD_INSERT:
            begin
                if (hit >= 0)
                begin
                    res.status    = ST_DUPLICATE;
                    res.found     = 1'b1;
                    res.value_out = table_vals[hit];
                end
                else if (table_count >= TABLE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    table_keys[table_count] = r.key;
                    table_vals[table_count] = r.value;
                    table_count++;
                end
            end
            CMD_READ_POS:
            begin
                if (int'(r.pos) >= table_count)
                    res.status = ST_FULL;
                else
                begin
                    res.found     = 1'b1;
                    res.key_out   = table_keys[r.pos];
                    res.value_out = table_vals[r.pos];
                end
            end
            CMD_CLEAR:
                table_count = 0;
            default:
            begin
                if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    res.found     = 1'b1;
                    res.value_out = table_vals[hit];
                    if (r.op == CMD_DELETE)
                    begin
                        for (int i = hit; i < table_count - 1; i++)
                        begin
                            table_keys[i] = table_keys[i+1];
                            table_vals[i] = table_vals[i+1];
                        end
                        table_count--;
                    end
                    else if (r.op == CMD_RENAME)
                        table_keys[hit] = r.new_key;
                    else if (r.op == CMD_WRITE)
                    begin
                        table_vals[hit] = r.value;
                        res.value_out   = r.value;
                    end
                end
            end
        endcase
        res.count = 5'(table_count);
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= '0;
            key      <= '0;
            new_key  <= '0;
            value    <= '0;
            position <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(apply_request(held_req));
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    held_req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= held_req.op;
                    key      <= held_req.key;
                    new_key  <= held_req.new_key;
                    value    <= held_req.value;
                    position <= held_req.pos;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: result with none expected, actual %h %b %h %h %h",
                             $time, status, found, key_out, value_out, count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("found", 32'(want.found), 32'(found));
                    check_field("key_out", want.key_out, key_out);
                    check_field("value_out", want.value_out, value_out);
                    check_field("count", 32'(want.count), 32'(count));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        logic [31:0] fill_key;
        for (int i = 0; i < KEY_POOL_N; i++)
            key_pool[i] = $urandom();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            @(negedge clk);
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            if (ph == 0)
            begin
                pending_requests.push_back(make_request(CMD_READ_POS, '0, '0, '0, 4'hf));
                pending_requests.push_back(make_request(CMD_READ, '0, '0, '0, '0));
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    fill_key = (i == TABLE_DEPTH - 1) ? 32'hffff_ffff : i * 32'h1111_1111;
                    pending_requests.push_back(make_request(CMD_INSERT, fill_key, '0,
                                                            ~fill_key, 4'(i)));
                end
                pending_requests.push_back(make_request(CMD_INSERT, 32'h1234_5678, '0,
                                                        32'h1, '0));
                pending_requests.push_back(make_request(CMD_INSERT, '0, '0, 32'h2, '0));
                pending_requests.push_back(make_request(CMD_READ_POS, '0, '0, '0, 4'hf));
                pending_requests.push_back(make_request(CMD_DELETE, '0, '0, '0, '0));
                pending_requests.push_back(make_request(CMD_RENAME, 32'h1111_1111,
                                                        32'hffff_ffff, '0, '0));
                pending_requests.push_back(make_request(CMD_EXISTS, 32'hffff_ffff, '0,
                                                        '0, '0));
                pending_requests.push_back(make_request(CMD_WRITE, 32'hffff_ffff, '0,
                                                        32'h5a5a_5a5a, '0));
                pending_requests.push_back(make_request(CMD_WRITE, '0, '0, 32'h3, '0));
                pending_requests.push_back(make_request(CMD_RENAME, '0, 32'h7, '0, '0));
                pending_requests.push_back(make_request(CMD_DELETE, '0, '0, '0, '0));
                pending_requests.push_back(make_request(CMD_READ_POS, '0, '0, '0, 4'hf));
                pending_requests.push_back(make_request(CMD_CLEAR, '0, '0, '0, '0));
            end
            repeat (RANDOM_PER_PHASE)
                pending_requests.push_back(random_request());
            while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
                @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### ordered_key_value_table_top.f
hw/rtl/okvt_pkg.sv
hw/rtl/okvt_ctrl.sv
hw/rtl/okvt_datapath.sv
hw/rtl/ordered_key_value_table_top.sv
verif/ordered_key_value_table_tb.sv
